// File: hdl/bvir_pkg.sv
// Shared types, codes and defaults of the buck voltage regulator.
package bvir_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_UP     = 2'd1;
  localparam logic [1:0] REQ_DOWN   = 2'd2;
  localparam logic [1:0] REQ_TOGGLE = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_DEADBAND    = 3'd1;
  localparam logic [2:0] REG_CAL_COEF0   = 3'd2;
  localparam logic [2:0] REG_CAL_COEF1   = 3'd3;
  localparam logic [2:0] REG_CAL_COEF2   = 3'd4;
  localparam logic [2:0] REG_CAL_COEF3   = 3'd5;
  localparam logic [2:0] REG_DUTY_LIMIT  = 3'd6;
  localparam logic [2:0] REG_TARGET_STEP = 3'd7;

  localparam int CAL_W = 40;
  localparam logic signed [CAL_W-1:0] CAL_COEF0_RST = 40'sd2553358058;
  localparam logic signed [CAL_W-1:0] CAL_COEF1_RST = 40'sd3487513445;
  localparam logic signed [CAL_W-1:0] CAL_COEF2_RST = 40'sd1696512;
  localparam logic signed [CAL_W-1:0] CAL_COEF3_RST = -40'sd126702;

  // Horner accumulator width (Q.32 volts, saturated)
  localparam int ACC_W = 48;

  typedef struct packed {
    logic       load;
    logic       mul_lo;
    logic       mul_hi;
    logic       div_init;
    logic       div_step;
    logic       horner_add;
    logic       volt_round;
    logic       err_eval;
    logic       gain_mul;
    logic       duty_upd;
    logic       other_op;
    logic       out_load;
    logic [1:0] coef_sel;
  } bvir_cmd_t;

endpackage

// File: hdl/bvir_cfg.sv
// APB register file holding gain, deadband, calibration, duty limit and target step.
module bvir_cfg #(
  parameter int FRAC_BITS = bvir_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [5:0]                      paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  output logic [FRAC_BITS+4:0]            prop_gain,
  output logic [FRAC_BITS:0]              deadband,
  output logic signed [bvir_pkg::CAL_W-1:0] cal_coef0,
  output logic signed [bvir_pkg::CAL_W-1:0] cal_coef1,
  output logic signed [bvir_pkg::CAL_W-1:0] cal_coef2,
  output logic signed [bvir_pkg::CAL_W-1:0] cal_coef3,
  output logic [FRAC_BITS+6:0]            duty_limit,
  output logic [FRAC_BITS:0]              target_step
);
  import bvir_pkg::*;

  localparam int GW = FRAC_BITS + 5;
  localparam int BW = FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 7;
  localparam logic [GW-1:0] GAIN_RST  = GW'(1) << FRAC_BITS;
  localparam logic [BW-1:0] DB_RST    = BW'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [BW-1:0] STEP_RST  = BW'(((2 << FRAC_BITS) + 5) / 10);
  localparam logic [DW-1:0] LIMIT_RST = DW'(98) << FRAC_BITS;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= GAIN_RST;
      deadband    <= DB_RST;
      cal_coef0   <= CAL_COEF0_RST;
      cal_coef1   <= CAL_COEF1_RST;
      cal_coef2   <= CAL_COEF2_RST;
      cal_coef3   <= CAL_COEF3_RST;
      duty_limit  <= LIMIT_RST;
      target_step <= STEP_RST;
    end else if (wr) begin
      case (idx)
        REG_PROP_GAIN:   prop_gain   <= pwdata[GW-1:0];
        REG_DEADBAND:    deadband    <= pwdata[BW-1:0];
        REG_CAL_COEF0:   cal_coef0   <= pwdata[CAL_W-1:0];
        REG_CAL_COEF1:   cal_coef1   <= pwdata[CAL_W-1:0];
        REG_CAL_COEF2:   cal_coef2   <= pwdata[CAL_W-1:0];
        REG_CAL_COEF3:   cal_coef3   <= pwdata[CAL_W-1:0];
        REG_DUTY_LIMIT:  duty_limit  <= pwdata[DW-1:0];
        REG_TARGET_STEP: target_step <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:   prdata = 64'(prop_gain);
      REG_DEADBAND:    prdata = 64'(deadband);
      REG_CAL_COEF0:   prdata = {{(64-CAL_W){cal_coef0[CAL_W-1]}}, cal_coef0};
      REG_CAL_COEF1:   prdata = {{(64-CAL_W){cal_coef1[CAL_W-1]}}, cal_coef1};
      REG_CAL_COEF2:   prdata = {{(64-CAL_W){cal_coef2[CAL_W-1]}}, cal_coef2};
      REG_CAL_COEF3:   prdata = {{(64-CAL_W){cal_coef3[CAL_W-1]}}, cal_coef3};
      REG_DUTY_LIMIT:  prdata = 64'(duty_limit);
      REG_TARGET_STEP: prdata = 64'(target_step);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: hdl/bvir_dp.sv
// Datapath: cubic calibration, error, proportional duty step, target and enable.
module bvir_dp #(
  parameter int ADC_BITS  = bvir_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = bvir_pkg::FRAC_BITS_DEF,
  parameter int OUT_TW    = 96
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bvir_pkg::bvir_cmd_t               cmd,
  input  logic [1:0]                        req_in,
  input  logic [ADC_BITS-1:0]               sample_in,
  input  logic [FRAC_BITS+4:0]              prop_gain,
  input  logic [FRAC_BITS:0]                deadband,
  input  logic signed [bvir_pkg::CAL_W-1:0] cal_coef0,
  input  logic signed [bvir_pkg::CAL_W-1:0] cal_coef1,
  input  logic signed [bvir_pkg::CAL_W-1:0] cal_coef2,
  input  logic signed [bvir_pkg::CAL_W-1:0] cal_coef3,
  input  logic [FRAC_BITS+6:0]              duty_limit,
  input  logic [FRAC_BITS:0]                target_step,
  output logic [OUT_TW-1:0]                 out_data
);
  import bvir_pkg::*;

  localparam int A      = ADC_BITS;
  localparam int F      = FRAC_BITS;
  localparam int DW     = F + 7;
  localparam int VW     = F + 6;
  localparam int GW     = F + 5;
  localparam int BW     = F + 1;
  localparam int LO_W   = ACC_W / 2;
  localparam int PL_W   = LO_W + A;
  localparam int PH_W   = LO_W + A + 1;
  localparam int PROD_W = ACC_W + A;
  localparam int DIG_N  = (PROD_W + 7) / 8;
  localparam int DIV_W  = DIG_N * 8;
  localparam int SUM_W  = DIV_W + 2;
  localparam int GP_W   = VW + GW;
  localparam int DL_W   = GP_W + 2;
  localparam int PAY_W  = 2 * DW + 2 * VW + 1;
  localparam logic [VW-1:0]    VMAX     = VW'(40) << F;
  localparam logic [DW-1:0]    DUTY_RST = DW'(50) << F;
  localparam logic [VW-1:0]    TGT_RST  = VW'(5) << F;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (31 - F);
  localparam logic [GP_W:0]    GP_HALF  = (GP_W + 1)'(1) << (F - 1);
  // floor(v * RECIP / 2^22) equals v / 100 for every v below 25600
  localparam logic [15:0]      RECIP    = 16'd41944;
  localparam logic [6:0]       DIVISOR  = 7'd100;

  // architectural state
  logic [DW-1:0] duty;
  logic [VW-1:0] target;
  logic          en;
  logic [VW-1:0] lastv;

  // working registers
  logic [1:0]              req;
  logic [A-1:0]            r;
  logic [DW-1:0]           applied;
  logic signed [ACC_W-1:0] acc;
  logic [PL_W-1:0]         pl;
  logic signed [PROD_W-1:0] prod;
  logic                    pneg;
  logic [DIV_W-1:0]        dvd;
  logic [DIV_W-1:0]        quot;
  logic [6:0]              rem;
  logic                    eneg;
  logic [VW-1:0]           emag;
  logic [DW-1:0]           dcl;
  logic                    outside;
  logic [GP_W-1:0]         gp;

  // combinational helpers
  logic signed [PH_W-1:0]   ph;
  logic signed [PROD_W:0]   psum;
  logic [PROD_W-1:0]        pmag;
  logic [14:0]              dv;
  logic [31:0]              dq_full;
  logic [7:0]               dq;
  logic [6:0]               drem;
  logic signed [CAL_W-1:0]  coef;
  logic signed [SUM_W-1:0]  qs;
  logic signed [SUM_W-1:0]  hsum;
  logic [SUM_W-ACC_W:0]     htop;
  logic signed [ACC_W-1:0]  hsat;
  logic [ACC_W-1:0]         vr;
  logic [VW-1:0]            vcal;
  logic signed [VW:0]       err;
  logic [GP_W:0]            gpr;
  logic [DL_W-1:0]          delta;
  logic [DL_W-1:0]          dsum;
  logic [DW-1:0]            duty_next;
  logic [VW:0]              tup;
  logic [VW-1:0]            target_next;
  logic [PAY_W-1:0]         pay;

  always_comb begin
    ph   = $signed(acc[ACC_W-1:LO_W]) * $signed({1'b0, r});
    psum = $signed({ph, {LO_W{1'b0}}}) + $signed({{(PROD_W + 1 - PL_W){1'b0}}, pl});
    pmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

    dv      = {rem, dvd[DIV_W-1 -: 8]};
    dq_full = 32'(dv) * 32'(RECIP);
    dq      = dq_full[29:22];
    drem    = 7'(dv - 15'(dq) * 15'(DIVISOR));

    case (cmd.coef_sel)
      2'd2:    coef = cal_coef2;
      2'd1:    coef = cal_coef1;
      default: coef = cal_coef0;
    endcase
    qs   = pneg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    hsum = qs + $signed({{(SUM_W - CAL_W){coef[CAL_W-1]}}, coef});
    htop = hsum[SUM_W-1:ACC_W-1];
    if (htop == '0 || htop == '1) begin
      hsat = hsum[ACC_W-1:0];
    end else if (hsum[SUM_W-1]) begin
      hsat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      hsat = {1'b0, {(ACC_W-1){1'b1}}};
    end

    vr = ({1'b0, acc[ACC_W-2:0]} + RND_HALF) >> (32 - F);
    if (acc[ACC_W-1]) begin
      vcal = '0;
    end else if (vr > ACC_W'(VMAX)) begin
      vcal = VMAX;
    end else begin
      vcal = vr[VW-1:0];
    end

    err = $signed({1'b0, target}) - $signed({1'b0, lastv});

    gpr   = {1'b0, gp} + GP_HALF;
    delta = DL_W'(gpr >> F);
    dsum  = DL_W'(dcl) + delta;
    if (!outside) begin
      duty_next = dcl;
    end else if (eneg) begin
      duty_next = (delta >= DL_W'(dcl)) ? '0 : DW'(DL_W'(dcl) - delta);
    end else begin
      duty_next = (dsum > DL_W'(duty_limit)) ? duty_limit : dsum[DW-1:0];
    end

    tup = {1'b0, target} + (VW + 1)'(target_step);
    case (req)
      REQ_UP:   target_next = (tup > (VW + 1)'(VMAX)) ? VMAX : tup[VW-1:0];
      REQ_DOWN: target_next = (VW'(target_step) >= target) ? '0
                              : target - VW'(target_step);
      default:  target_next = target;
    endcase

    pay = {en, target, lastv, duty, applied};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty   <= DUTY_RST;
      target <= TGT_RST;
      en     <= 1'b0;
      lastv  <= '0;
    end else begin
      if (cmd.volt_round) lastv <= vcal;
      if (cmd.duty_upd)   duty  <= duty_next;
      if (cmd.other_op) begin
        target <= target_next;
        if (req == REQ_TOGGLE) en <= ~en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= req_in;
      r       <= sample_in;
      applied <= duty;
      acc     <= {{(ACC_W - CAL_W){cal_coef3[CAL_W-1]}}, cal_coef3};
    end
    if (cmd.mul_lo) pl <= PL_W'(acc[LO_W-1:0]) * PL_W'(r);
    if (cmd.mul_hi) prod <= psum[PROD_W-1:0];
    if (cmd.div_init) begin
      pneg <= prod[PROD_W-1];
      dvd  <= DIV_W'(pmag);
      quot <= '0;
      rem  <= '0;
    end
    if (cmd.div_step) begin
      dvd  <= dvd << 8;
      quot <= {quot[DIV_W-9:0], dq};
      rem  <= drem;
    end
    if (cmd.horner_add) acc <= hsat;
    if (cmd.err_eval) begin
      eneg    <= err[VW];
      emag    <= err[VW] ? VW'(-err) : VW'(err);
      dcl     <= (duty > duty_limit) ? duty_limit : duty;
      outside <= ((err[VW] ? VW'(-err) : VW'(err)) >= VW'(deadband)) && en;
    end
    if (cmd.gain_mul) gp <= GP_W'(emag) * GP_W'(prop_gain);
    if (cmd.out_load) out_data <= OUT_TW'(pay);
  end

endmodule

// File: hdl/bvir_ctrl.sv
// Sequencer: stream handshakes and the step order of the calibration and update.
module bvir_ctrl #(
  parameter int ADC_BITS = bvir_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          req_type,
  output logic                m_tvalid,
  input  logic                m_tready,
  output bvir_pkg::bvir_cmd_t cmd
);
  import bvir_pkg::*;

  localparam int DIG_N = (ACC_W + ADC_BITS + 7) / 8;
  localparam int DCW   = $clog2(DIG_N);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MULLO = 4'd1;
  localparam logic [3:0] ST_MULHI = 4'd2;
  localparam logic [3:0] ST_DINIT = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_ADD   = 4'd5;
  localparam logic [3:0] ST_VRND  = 4'd6;
  localparam logic [3:0] ST_ERR   = 4'd7;
  localparam logic [3:0] ST_GMUL  = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;
  localparam logic [3:0] ST_OTHER = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  logic [3:0]     state, state_next;
  logic [1:0]     coef_k, coef_k_next;
  logic [DCW-1:0] dcnt, dcnt_next;
  logic           out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    coef_k_next = coef_k;
    dcnt_next   = dcnt;
    cmd         = '0;
    cmd.coef_sel = coef_k;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load    = 1'b1;
          coef_k_next = 2'd2;
          state_next  = (req_type == REQ_SAMPLE) ? ST_MULLO : ST_OTHER;
        end
      end
      ST_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MULHI;
      end
      ST_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        dcnt_next    = DCW'(DIG_N - 1);
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt - 1'b1;
        if (dcnt == '0) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.horner_add = 1'b1;
        coef_k_next    = coef_k - 1'b1;
        state_next     = (coef_k == 2'd0) ? ST_VRND : ST_MULLO;
      end
      ST_VRND: begin
        cmd.volt_round = 1'b1;
        state_next     = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_eval = 1'b1;
        state_next   = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.gain_mul = 1'b1;
        state_next   = ST_UPD;
      end
      ST_UPD: begin
        cmd.duty_upd = 1'b1;
        state_next   = ST_FIN;
      end
      ST_OTHER: begin
        cmd.other_op = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      coef_k   <= '0;
      dcnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      coef_k <= coef_k_next;
      dcnt   <= dcnt_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/buck_voltage_incremental_regulator_unit.sv
// Top level of the buck voltage regulator: register file, sequencer and datapath.
//
//  channel  dir  word contents
//  s_*      in   tuser: req_type; tdata: adc_sample
//  m_*      out  tdata: applied_duty, next_duty, measured_voltage, target_voltage,
//                output_enabled
//  APB      in   eight 64-bit registers at byte address 8*index
//
// A sample word runs three Horner steps, each a split 24-bit multiply and an
// 8-bit-a-cycle division by 100, then the voltage, error and duty steps.
// Target and enable words skip the calibration and go straight to their update.
// One word is in work at a time; a finished result waits in the output register,
// and a new word is accepted while it waits. Reset is synchronous and restores
// the register defaults and the regulator state.
module buck_voltage_incremental_regulator_unit #(
  parameter int ADC_BITS  = bvir_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = bvir_pkg::FRAC_BITS_DEF,
  parameter int IN_TW     = ((ADC_BITS + 7) / 8) * 8,
  parameter int OUT_TW    = ((4 * FRAC_BITS + 27 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // adc_sample
  input  logic [1:0]        s_tuser,   // req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata,   // applied_duty, next_duty, measured_voltage,
                                       // target_voltage, output_enabled
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import bvir_pkg::*;

  bvir_cmd_t                cmd;
  logic [FRAC_BITS+4:0]     prop_gain;
  logic [FRAC_BITS:0]       deadband;
  logic signed [CAL_W-1:0]  cal_coef0;
  logic signed [CAL_W-1:0]  cal_coef1;
  logic signed [CAL_W-1:0]  cal_coef2;
  logic signed [CAL_W-1:0]  cal_coef3;
  logic [FRAC_BITS+6:0]     duty_limit;
  logic [FRAC_BITS:0]       target_step;

  bvir_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .prop_gain   (prop_gain),
    .deadband    (deadband),
    .cal_coef0   (cal_coef0),
    .cal_coef1   (cal_coef1),
    .cal_coef2   (cal_coef2),
    .cal_coef3   (cal_coef3),
    .duty_limit  (duty_limit),
    .target_step (target_step)
  );

  bvir_ctrl #(
    .ADC_BITS(ADC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bvir_dp #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS),
    .OUT_TW    (OUT_TW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_in      (s_tuser),
    .sample_in   (s_tdata[ADC_BITS-1:0]),
    .prop_gain   (prop_gain),
    .deadband    (deadband),
    .cal_coef0   (cal_coef0),
    .cal_coef1   (cal_coef1),
    .cal_coef2   (cal_coef2),
    .cal_coef3   (cal_coef3),
    .duty_limit  (duty_limit),
    .target_step (target_step),
    .out_data    (m_tdata)
  );

endmodule

// File: tb/tb_regulator_pkg.sv
`timescale 1ns / 100ps
// Regulator scoreboard: duty/target tracker and queue of expected result words.
package tb_regulator_pkg;
  import bvir_pkg::*;

  localparam int     DUTY_W   = 23;
  localparam int     VOLT_W   = 22;
  localparam longint VOLT_MAX = 40 * 65536;
  localparam longint ACC_HI   = 64'sd140737488355327;
  localparam longint ACC_LO   = -ACC_HI - 1;

  typedef struct packed {
    logic              enabled;
    logic [VOLT_W-1:0] target;
    logic [VOLT_W-1:0] measured;
    logic [DUTY_W-1:0] next_duty;
    logic [DUTY_W-1:0] applied;
  } tick_result_t;

  class regulator_scoreboard;
    longint       gain, band, duty_lim, step;
    longint       coef[4];
    longint       duty, target, last_volts;
    bit           enabled;
    tick_result_t pending[$];
    int           errors;

    function new();
      gain       = 65536;
      band       = 6554;
      coef[0]    = CAL_COEF0_RST;
      coef[1]    = CAL_COEF1_RST;
      coef[2]    = CAL_COEF2_RST;
      coef[3]    = CAL_COEF3_RST;
      duty_lim   = 98 * 65536;
      step       = 13107;
      duty       = 50 * 65536;
      target     = 5 * 65536;
      enabled    = 1'b0;
      last_volts = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      logic signed [CAL_W-1:0] c;
      c = val[CAL_W-1:0];
      case (idx)
        REG_PROP_GAIN:   gain = val[20:0];
        REG_DEADBAND:    band = val[16:0];
        REG_CAL_COEF0:   coef[0] = c;
        REG_CAL_COEF1:   coef[1] = c;
        REG_CAL_COEF2:   coef[2] = c;
        REG_CAL_COEF3:   coef[3] = c;
        REG_DUTY_LIMIT:  duty_lim = val[DUTY_W-1:0];
        REG_TARGET_STEP: step = val[16:0];
      endcase
    endfunction

    // cubic in Horner form on the raw reading, Q.32 saturated to 48 bits
    function longint calibrate_volts(logic [11:0] r);
      longint acc, rr;
      int     k;
      acc = coef[3];
      rr  = r;
      for (k = 2; k >= 0; k--) begin
        acc = acc * rr / 100 + coef[k];
        if (acc > ACC_HI) acc = ACC_HI;
        else if (acc < ACC_LO) acc = ACC_LO;
      end
      if (acc < 0) acc = 0;
      acc = (acc + 32768) >>> 16;
      return acc > VOLT_MAX ? VOLT_MAX : acc;
    endfunction

    function void note_word(logic [1:0] req, logic [11:0] adc);
      tick_result_t r;
      longint       v, err, mag, d, delta;
      r.applied = duty[DUTY_W-1:0];
      case (req)
        REQ_SAMPLE: begin
          v   = calibrate_volts(adc);
          err = target - v;
          mag = err < 0 ? -err : err;
          d   = duty > duty_lim ? duty_lim : duty;
          last_volts = v;
          if (mag >= band && enabled) begin
            delta = (mag * gain + 32768) >>> 16;
            if (err < 0) d = delta >= d ? 0 : d - delta;
            else d = d + delta > duty_lim ? duty_lim : d + delta;
          end
          duty = d;
        end
        REQ_UP:     target = target + step > VOLT_MAX ? VOLT_MAX : target + step;
        REQ_DOWN:   target = step >= target ? 0 : target - step;
        REQ_TOGGLE: enabled = !enabled;
      endcase
      r.next_duty = duty[DUTY_W-1:0];
      r.measured  = last_volts[VOLT_W-1:0];
      r.target    = target[VOLT_W-1:0];
      r.enabled   = enabled;
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task compare(string name, logic [31:0] e, logic [31:0] g);
      if (g !== e) report($sformatf("%s expected %0d got %0d", name, e, g));
    endtask

    task check_word(tick_result_t got);
      tick_result_t w;
      if (pending.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      w = pending.pop_front();
      compare("applied_duty", w.applied, got.applied);
      compare("next_duty", w.next_duty, got.next_duty);
      compare("measured_voltage", w.measured, got.measured);
      compare("target_voltage", w.target, got.target);
      compare("output_enabled", w.enabled, got.enabled);
    endtask

    task check_leftover();
      if (pending.size() != 0)
        report($sformatf("%0d result words never arrived", pending.size()));
    endtask
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the buck regulator testbench: clock, reset, stream and APB drivers, checks.
module tb_top;
  import bvir_pkg::*;
  import tb_regulator_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // adc_sample
  logic [1:0]  s_tuser = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // applied_duty, next_duty, measured_voltage,
                               // target_voltage, output_enabled
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  regulator_scoreboard sb;
  tick_result_t        out_word;
  bit                  stall_on = 1'b0;
  bit                  gaps_on = 1'b0;
  bit                  long_hold = 1'b0;
  int                  quiet = 0;

  assign out_word = m_tdata[$bits(tick_result_t)-1:0];

  buck_voltage_incremental_regulator_unit i_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(out_word);
      if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata[11:0]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("buck_voltage_incremental_regulator_unit test failed");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  always begin
    @(posedge clk);
    if (long_hold) begin
      m_tready <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk);
      long_hold = 1'b0;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic write_all(logic [63:0] g, logic [63:0] b, logic [63:0] c0,
                           logic [63:0] c1, logic [63:0] c2, logic [63:0] c3,
                           logic [63:0] lim, logic [63:0] stp);
    reg_write(REG_PROP_GAIN, g);
    reg_write(REG_DEADBAND, b);
    reg_write(REG_CAL_COEF0, c0);
    reg_write(REG_CAL_COEF1, c1);
    reg_write(REG_CAL_COEF2, c2);
    reg_write(REG_CAL_COEF3, c3);
    reg_write(REG_DUTY_LIMIT, lim);
    reg_write(REG_TARGET_STEP, stp);
  endtask

  task automatic send_word(logic [1:0] req, logic [11:0] adc);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tuser  <= req;
    s_tdata  <= {4'b0000, adc};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic send_random(int up_pct);
    int          pick;
    logic [11:0] adc;
    longint      guess;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: adc = 12'($urandom);
        1: adc = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        default: begin
          // reading near the one that maps to the target under the default curve
          guess = int'($urandom_range(0, 40)) - 20 + sb.target / 532 - 73;
          if (guess < 0) guess = 0;
          if (guess > 4095) guess = 4095;
          adc = guess[11:0];
        end
      endcase
      send_word(REQ_SAMPLE, adc);
    end else if (pick < 70 + up_pct) begin
      send_word(REQ_UP, 12'($urandom));
    end else if (pick < 94) begin
      send_word(REQ_DOWN, 12'($urandom));
    end else begin
      send_word(REQ_TOGGLE, 12'($urandom));
    end
  endtask

  task automatic run_phase(int n, int up_pct, bit hold_once);
    int i;
    for (i = 0; i < n; i++) begin
      if (hold_once && i == 20) long_hold = 1'b1;
      send_random(up_pct);
    end
    wait_drained();
  endtask

  initial begin
    logic [63:0] r0, r1, r2, r3;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, output off then on, deadband, target moves
    send_word(REQ_SAMPLE, 12'h000);
    send_word(REQ_SAMPLE, 12'hfff);
    send_word(REQ_TOGGLE, 12'h000);
    send_word(REQ_SAMPLE, 12'h000);
    send_word(REQ_SAMPLE, 12'hfff);
    send_word(REQ_SAMPLE, 12'd543);
    send_word(REQ_UP, 12'hfff);
    send_word(REQ_UP, 12'h000);
    send_word(REQ_DOWN, 12'h5a5);
    send_word(REQ_SAMPLE, 12'h800);
    send_word(REQ_TOGGLE, 12'h0ff);
    send_word(REQ_SAMPLE, 12'd100);
    send_word(REQ_TOGGLE, 12'hf00);
    wait_drained();

    // held duty above a lowered limit, zero deadband, target floor
    reg_write(REG_DUTY_LIMIT, 64'd1310720);
    reg_write(REG_DEADBAND, 64'd0);
    reg_write(REG_TARGET_STEP, 64'd65536);
    send_word(REQ_SAMPLE, 12'd543);
    repeat (6) send_word(REQ_DOWN, 12'h000);
    send_word(REQ_SAMPLE, 12'h000);
    wait_drained();

    // calibration extremes: clamp at 40 V, clamp at 0, accumulator saturation
    reg_write(REG_CAL_COEF0, 64'h0000_007f_ffff_ffff);
    send_word(REQ_SAMPLE, 12'hfff);
    wait_drained();
    reg_write(REG_CAL_COEF0, 64'hffff_ff80_0000_0000);
    send_word(REQ_SAMPLE, 12'h000);
    wait_drained();
    reg_write(REG_CAL_COEF0, CAL_COEF0_RST);
    reg_write(REG_CAL_COEF3, 64'h0000_007f_ffff_ffff);
    send_word(REQ_SAMPLE, 12'hfff);
    wait_drained();

    // high extremes, target pushed to its ceiling
    stall_on = 1'b1;
    gaps_on  = 1'b1;
    write_all(64'd1048576, 64'd65536, CAL_COEF0_RST, CAL_COEF1_RST, CAL_COEF2_RST,
              CAL_COEF3_RST, 64'd6553600, 64'd65536);
    run_phase(110, 22, 1'b0);

    // low extremes
    gaps_on = 1'b0;
    write_all(64'd0, 64'd0, CAL_COEF0_RST, CAL_COEF1_RST, CAL_COEF2_RST,
              CAL_COEF3_RST, 64'd0, 64'd0);
    run_phase(100, 12, 1'b0);

    // wild calibration, upper bits of the coefficient writes are don't-care
    stall_on = 1'b0;
    gaps_on  = 1'b1;
    write_all($urandom_range(0, 1048576), $urandom_range(0, 65536),
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, $urandom_range(0, 6553600), $urandom_range(0, 65536));
    run_phase(100, 12, 1'b0);

    // moderate random settings, at least one long output hold-off
    repeat (2) begin
      stall_on = 1'b1;
      r0 = CAL_COEF0_RST + int'($urandom_range(0, 1 << 28)) - (1 << 27);
      r1 = CAL_COEF1_RST + int'($urandom_range(0, 1 << 28)) - (1 << 27);
      r2 = CAL_COEF2_RST + int'($urandom_range(0, 1 << 20)) - (1 << 19);
      r3 = CAL_COEF3_RST + int'($urandom_range(0, 1 << 16)) - (1 << 15);
      write_all($urandom_range(0, 1048576), $urandom_range(0, 65536), r0, r1, r2, r3,
                $urandom_range(0, 6553600), $urandom_range(0, 65536));
      run_phase(110, 12, !long_hold && r0[0]);
    end
    long_hold = 1'b1;
    run_phase(40, 12, 1'b0);

    // defaults back, no idling at all
    stall_on = 1'b0;
    gaps_on  = 1'b0;
    write_all(64'd65536, 64'd6554, CAL_COEF0_RST, CAL_COEF1_RST, CAL_COEF2_RST,
              CAL_COEF3_RST, 64'd6422528, 64'd13107);
    run_phase(70, 12, 1'b0);

    repeat (60) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("buck_voltage_incremental_regulator_unit test passed");
    end else begin
      $display("buck_voltage_incremental_regulator_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bvir_pkg.sv
hdl/bvir_cfg.sv
hdl/bvir_dp.sv
hdl/bvir_ctrl.sv
hdl/buck_voltage_incremental_regulator_unit.sv
tb/tb_regulator_pkg.sv
tb/tb_top.sv
